@@ hdl/ecps_pkg.sv @@
// Shared types, codes and constants of the earliest completion path scheduler.
package ecps_pkg;

  localparam int MAX_PATHS_DEF = 8;

  localparam logic [15:0] SEGMENT_SIZE_RST = 16'd1200;
  localparam logic [19:0] MIN_RATE_RST     = 20'd1000;
  localparam logic [23:0] DEF_RTT_RST      = 24'd100000;

  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [39:0] RATE_MAX     = {40{1'b1}};
  localparam logic [47:0] INFLIGHT_MAX = {48{1'b1}};
  localparam logic [63:0] TIME_MAX     = {64{1'b1}};

  // Divider sizing: numerator holds (inflight + segment) * 1e6 or cwnd * 1e6, denominator a rate or an RTT.
  localparam int DIV_NUM_W = 72;
  localparam int DIV_DEN_W = 40;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SENT   = 3'd2,
    OP_ACK    = 3'd3,
    OP_LOSS   = 3'd4,
    OP_SELECT = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_SEGMENT  = 2'd0,
    CFG_MIN_RATE = 2'd1,
    CFG_DEF_RTT  = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [7:0]  path_id;
    logic        usable;
    logic [31:0] byte_count;
    logic [39:0] measured_bandwidth;
    logic [31:0] congestion_window;
    logic [31:0] smoothed_rtt;
  } ecps_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  primary_path;
    logic [7:0]  backup_path;
    logic        backup_valid;
    logic [63:0] best_completion;
    logic        switched;
  } ecps_out_t;

  // One row of the path memory.
  typedef struct packed {
    logic        usable;
    logic [47:0] inflight;
    logic [39:0] rate;
    logic [31:0] rtt;
  } entry_t;

endpackage

@@ hdl/ecps_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ecps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ecps_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
module ecps_div import ecps_pkg::*; #(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = DIV_DEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        acc_q  <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        cnt_q  <= CNT_W'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // shift in the next numerator bit, subtract when it fits
        rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        acc_q <= {acc_q[NUM_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

@@ hdl/earliest_completion_path_scheduler_core.sv @@
// Top level of the earliest completion path scheduler.
//
// Keeps up to MAX_PATHS path entries. Valid bits and path ids sit in flops for
// a combinational id lookup; usable, inflight bytes, rate and RTT sit in one
// synchronous RAM (registered read) that add, sent, ack and loss read, modify
// and write back (an add or sent that allocates starts from a fresh entry
// instead of reading) and that select only reads. A command is taken when
// start is high and busy is low; its single result appears on res_o for
// exactly one cycle with result_valid_o, and cannot be held off. Remove,
// unknown entry, table full and unused op answer directly from idle. Add,
// sent, ack and loss otherwise go through the modify step and write back; a
// rate from cwnd / RTT (add, ack, or a sent that allocates) takes a two-step
// multiply and the shared bit-serial divider. Select visits every slot, skips
// empty and unusable entries, and runs each usable entry with a nonzero rate
// through the same multiply and divider. Busy holds off any new command.
// Configuration is always ready; it is to be written by the user only while
// busy is low and no result is pending, which the block does not enforce.
module earliest_completion_path_scheduler_core import ecps_pkg::*; #(
  parameter int MAX_PATHS = MAX_PATHS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ecps_in_t  in_i,
  output logic      result_valid_o,
  output ecps_out_t res_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int IW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int CW = $clog2(MAX_PATHS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,
    S_MOD,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_FIN,
    S_WB,
    S_SEL_NEXT,
    S_SEL_RD,
    S_SEL_CMP
  } state_e;

  state_e state_q;

  // configuration
  logic [15:0] seg_q;
  logic [19:0] min_rate_q;
  logic [23:0] def_rtt_q;

  // tag side of the table
  logic [MAX_PATHS-1:0] valid_q;
  logic [7:0]           path_q [MAX_PATHS];

  logic [7:0] cur_path_q;
  logic       cur_valid_q;

  // command in progress
  ecps_in_t    in_q;
  entry_t      ent_q;
  logic [IW-1:0] slot_q;
  logic        alloc_q;
  logic [48:0] mul_op_q;
  logic [44:0] prod_lo_q;

  // select scan
  logic [CW-1:0] scan_q;
  logic [IW-1:0] best_q;
  logic [IW-1:0] second_q;
  logic          best_found_q;
  logic          second_found_q;
  logic [63:0]   bmin_q;
  logic [63:0]   smin_q;
  logic [63:0]   cand_q;

  ecps_out_t res_q;
  logic      res_valid_q;

  // lookup: matching slot and first free slot
  logic          hit_any;
  logic [IW-1:0] hit_idx;
  logic          free_any;
  logic [IW-1:0] free_idx;

  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_PATHS - 1; i >= 0; i--) begin
      if (valid_q[i] && path_q[i] == in_i.path_id) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  logic [IW-1:0] scan_idx;
  assign scan_idx = scan_q[IW-1:0];

  // entry memory
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  assign ram_we    = (state_q == S_WB);
  assign ram_raddr = (state_q == S_IDLE) ? hit_idx : scan_idx;

  ecps_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_PATHS)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(slot_q),
    .wdata_i(ent_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // multiply by 1e6 in two halves, then divide
  logic [44:0] lo_prod;
  logic [43:0] hi_prod;
  logic [71:0] prod_full;
  logic        sel_mode;
  logic        div_start;
  logic        div_done;
  logic [71:0] div_quo;
  logic [39:0] div_den;

  assign lo_prod   = mul_op_q[24:0] * USEC_PER_SEC;
  assign hi_prod   = mul_op_q[48:25] * USEC_PER_SEC;
  assign prod_full = 72'(prod_lo_q) + 72'({hi_prod, 25'b0});
  assign sel_mode  = (in_q.op == OP_SELECT);
  assign div_start = (state_q == S_MUL_HI);
  assign div_den   = sel_mode ? ent_q.rate : 40'(ent_q.rtt);

  ecps_div #(
    .NUM_W(DIV_NUM_W),
    .DEN_W(DIV_DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (prod_full),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // completion estimate from quotient, saturating at the top
  logic [64:0] cand_sum;
  logic [63:0] cand_calc;
  logic [39:0] rate_calc;

  assign cand_sum  = {1'b0, div_quo[63:0]} + 65'(ent_q.rtt);
  assign cand_calc = (div_quo[71:64] != '0 || cand_sum[64]) ? TIME_MAX : cand_sum[63:0];
  assign rate_calc = (div_quo[71:40] != '0) ? RATE_MAX : div_quo[39:0];

  // inflight accounting
  logic [48:0] sent_sum;
  logic [47:0] sent_sat;
  logic [47:0] drop_sub;

  assign sent_sum = {1'b0, ent_q.inflight} + 49'(in_q.byte_count);
  assign sent_sat = sent_sum[48] ? INFLIGHT_MAX : sent_sum[47:0];
  assign drop_sub = (ent_q.inflight >= 48'(in_q.byte_count))
                  ? ent_q.inflight - 48'(in_q.byte_count) : '0;

  logic need_refresh;
  assign need_refresh = (in_q.op == OP_ADD) || (in_q.op == OP_ACK) ||
                        ((in_q.op == OP_SENT) && alloc_q);

  logic       new_switch;
  assign new_switch = !cur_valid_q || (cur_path_q != path_q[best_q]);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q      <= SEGMENT_SIZE_RST;
      min_rate_q <= MIN_RATE_RST;
      def_rtt_q  <= DEF_RTT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SEGMENT:  seg_q      <= cfg_data_i[15:0];
        CFG_MIN_RATE: min_rate_q <= cfg_data_i[19:0];
        CFG_DEF_RTT:  def_rtt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      valid_q        <= '0;
      path_q         <= '{default: '0};
      cur_path_q     <= '0;
      cur_valid_q    <= 1'b0;
      in_q           <= '0;
      ent_q          <= '0;
      slot_q         <= '0;
      alloc_q        <= 1'b0;
      mul_op_q       <= '0;
      prod_lo_q      <= '0;
      scan_q         <= '0;
      best_q         <= '0;
      second_q       <= '0;
      best_found_q   <= 1'b0;
      second_found_q <= 1'b0;
      bmin_q         <= TIME_MAX;
      smin_q         <= TIME_MAX;
      cand_q         <= '0;
      res_q          <= '0;
      res_valid_q    <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            in_q    <= in_i;
            alloc_q <= 1'b0;
            res_q   <= '0;
            unique case (op_e'(in_i.op))
              OP_ADD, OP_SENT: begin
                if (hit_any) begin
                  slot_q  <= hit_idx;
                  state_q <= S_RD;
                end else if (free_any) begin
                  // allocate: fresh entry, then fall into the modify step
                  slot_q            <= free_idx;
                  valid_q[free_idx] <= 1'b1;
                  path_q[free_idx]  <= in_i.path_id;
                  ent_q.usable      <= 1'b0;
                  ent_q.inflight    <= '0;
                  ent_q.rate        <= 40'(min_rate_q);
                  ent_q.rtt         <= 32'(def_rtt_q);
                  alloc_q           <= 1'b1;
                  state_q           <= S_MOD;
                end else begin
                  res_q.status <= ST_FULL;
                  res_valid_q  <= 1'b1;
                end
              end
              OP_REMOVE: begin
                if (hit_any) begin
                  valid_q[hit_idx] <= 1'b0;
                end else begin
                  res_q.status <= ST_UNKNOWN;
                end
                if (cur_valid_q && cur_path_q == in_i.path_id) begin
                  cur_valid_q <= 1'b0;
                end
                res_valid_q <= 1'b1;
              end
              OP_ACK, OP_LOSS: begin
                if (hit_any) begin
                  slot_q  <= hit_idx;
                  state_q <= S_RD;
                end else begin
                  res_q.status <= ST_UNKNOWN;
                  res_valid_q  <= 1'b1;
                end
              end
              OP_SELECT: begin
                scan_q         <= '0;
                best_found_q   <= 1'b0;
                second_found_q <= 1'b0;
                bmin_q         <= TIME_MAX;
                smin_q         <= TIME_MAX;
                state_q        <= S_SEL_NEXT;
              end
              default: begin
                res_q.status <= ST_UNKNOWN;
                res_valid_q  <= 1'b1;
              end
            endcase
          end
        end

        S_RD: begin
          ent_q   <= ram_rdata;
          state_q <= S_MOD;
        end

        S_MOD: begin
          if (in_q.op == OP_ADD || in_q.op == OP_ACK) begin
            ent_q.usable <= in_q.usable;
          end
          if (in_q.op == OP_SENT) begin
            ent_q.inflight <= sent_sat;
          end
          if (in_q.op == OP_ACK || in_q.op == OP_LOSS) begin
            ent_q.inflight <= drop_sub;
          end
          if (need_refresh) begin
            priority if (in_q.measured_bandwidth != '0) begin
              ent_q.rate <= in_q.measured_bandwidth;
              state_q    <= S_FIN;
            end else if (in_q.congestion_window != '0 && ent_q.rtt != '0) begin
              mul_op_q <= 49'(in_q.congestion_window);
              state_q  <= S_MUL_LO;
            end else begin
              state_q <= S_FIN;
            end
          end else begin
            state_q <= S_WB;
          end
        end

        S_MUL_LO: begin
          prod_lo_q <= lo_prod;
          state_q   <= S_MUL_HI;
        end

        S_MUL_HI: begin
          state_q <= S_DIV;
        end

        S_DIV: begin
          if (div_done) begin
            if (sel_mode) begin
              cand_q  <= cand_calc;
              state_q <= S_SEL_CMP;
            end else begin
              ent_q.rate <= rate_calc;
              state_q    <= S_FIN;
            end
          end
        end

        S_FIN: begin
          // clamp the rate, then take the new RTT
          if (ent_q.rate < 40'(min_rate_q)) begin
            ent_q.rate <= 40'(min_rate_q);
          end
          if (in_q.smoothed_rtt != '0) begin
            ent_q.rtt <= in_q.smoothed_rtt;
          end
          state_q <= S_WB;
        end

        S_WB: begin
          res_q.status <= ST_OK;
          res_valid_q  <= 1'b1;
          state_q      <= S_IDLE;
        end

        S_SEL_NEXT: begin
          if (scan_q == CW'(MAX_PATHS)) begin
            if (best_found_q) begin
              res_q.status          <= ST_OK;
              res_q.primary_path    <= path_q[best_q];
              res_q.backup_path     <= second_found_q ? path_q[second_q] : 8'd0;
              res_q.backup_valid    <= second_found_q;
              res_q.best_completion <= bmin_q;
              res_q.switched        <= new_switch;
              cur_path_q            <= path_q[best_q];
              cur_valid_q           <= 1'b1;
            end else begin
              res_q.status <= ST_UNKNOWN;
            end
            res_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else if (valid_q[scan_idx]) begin
            state_q <= S_SEL_RD;
          end else begin
            scan_q <= scan_q + CW'(1);
          end
        end

        S_SEL_RD: begin
          ent_q <= ram_rdata;
          priority if (!ram_rdata.usable) begin
            scan_q  <= scan_q + CW'(1);
            state_q <= S_SEL_NEXT;
          end else if (ram_rdata.rate == '0) begin
            cand_q  <= TIME_MAX;
            state_q <= S_SEL_CMP;
          end else begin
            mul_op_q <= 49'(ram_rdata.inflight) + 49'(seg_q);
            state_q  <= S_MUL_LO;
          end
        end

        S_SEL_CMP: begin
          // strictly smaller wins, so ties keep the lower slot
          if (cand_q < bmin_q) begin
            second_q       <= best_q;
            second_found_q <= best_found_q;
            smin_q         <= bmin_q;
            best_q         <= scan_idx;
            best_found_q   <= 1'b1;
            bmin_q         <= cand_q;
          end else if (cand_q < smin_q) begin
            second_q       <= scan_idx;
            second_found_q <= 1'b1;
            smin_q         <= cand_q;
          end
          scan_q  <= scan_q + CW'(1);
          state_q <= S_SEL_NEXT;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

`ifndef NO_ASSERTIONS
  // a result only leaves once the sequencer is back at rest
  a_result_at_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (state_q == S_IDLE))
    else $error("result strobe outside idle");

  // a remove is answered in the following cycle
  a_remove_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.op == OP_REMOVE) |=> result_valid_o)
    else $error("remove not answered next cycle");

  // failed transactions carry no selection
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && res_o.status != ST_OK) |->
      (res_o.best_completion == '0 && !res_o.switched && !res_o.backup_valid))
    else $error("selection fields set on failed transaction");

  // the divider only finishes while the sequencer waits for it
  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider result with no waiting step");
`endif

endmodule
